// File: sv/itra_pkg.sv
// shared constants, beat types and control types for the radix ascii converter
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_LIMIT = (MAX_DIGITS > 64) ? 64 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
    localparam int BIT_W       = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [7:0]         CHAR_ZERO = 8'h30;
    localparam logic [7:0]         CHAR_A    = 8'h61;
    localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
    } item_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic pop;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic quot_zero;
        logic stack_full;
        logic one_left;
    } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/integer_to_radix_ascii_top.sv
// top level of the unsigned integer to radix ascii converter
// each digit is a full divider pass (ST_DIV) followed by a push (ST_PUSH) (one-bit restoring divider)
// first character is emitted in ST_EMIT, entered from ST_PUSH after the last digit push; n = digit count
// then one character per cycle, n characters in all, last flagged; busy drops the cycle after
// next beat accepted only once busy is low again, after the last character of the previous one
// async active-low reset returns to idle; no clearing pass, results are never stalled
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire itra_pkg::item_t   item,
    output logic                   busy,
    output logic                   strobe,
    output itra_pkg::result_t      result
);
    import itra_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    itra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    itra_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

`default_nettype wire

// File: sv/itra_dp.sv
// datapath: restoring divider by the radix, digit stack and ascii mapping
`timescale 1ns / 1ps
`default_nettype none

module itra_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire itra_pkg::item_t item,
    input  wire itra_pkg::dp_cmd_t cmd,
    output itra_pkg::dp_sts_t    sts,
    output itra_pkg::result_t    result
);
    import itra_pkg::*;

    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [DIGIT_W-1:0]    stack_reg [DIGIT_LIMIT];
    logic [DIGIT_W-1:0]    stack_next [DIGIT_LIMIT];

    logic [RADIX_W-1:0]    rem_sh;
    logic [RADIX_W-1:0]    rem_diff;
    logic                  q_bit;
    logic [RADIX_W-1:0]    radix_sat;
    logic [DIGIT_W-1:0]    top_digit;

    always_comb
    begin
        if (item.radix < RADIX_MIN)
            radix_sat = RADIX_MIN;
        else if (item.radix > RADIX_MAX)
            radix_sat = RADIX_MAX;
        else
            radix_sat = item.radix;
    end

    // one quotient bit per step
    assign rem_sh   = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign q_bit    = (rem_sh >= radix_reg);
    assign rem_diff = rem_sh - radix_reg;

    always_comb
    begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        bit_cnt_next = bit_cnt_reg;
        n_next       = n_reg;
        stack_next   = stack_reg;

        if (cmd.load)
        begin
            quot_next    = item.value;
            rem_next     = '0;
            radix_next   = radix_sat;
            bit_cnt_next = '0;
            n_next       = '0;
        end
        else if (cmd.step)
        begin
            quot_next    = {quot_reg[VALUE_BITS-2:0], q_bit};
            rem_next     = q_bit ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
            bit_cnt_next = bit_cnt_reg + BIT_W'(1);
        end
        else if (cmd.push)
        begin
            stack_next[0] = rem_reg;
            for (int i = 1; i < DIGIT_LIMIT; i++)
                stack_next[i] = stack_reg[i-1];
            rem_next     = '0;
            bit_cnt_next = '0;
            n_next       = n_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DIGIT_LIMIT - 1; i++)
                stack_next[i] = stack_reg[i+1];
            stack_next[DIGIT_LIMIT-1] = '0;
            n_next = n_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            n_reg       <= '0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        stack_reg <= stack_next;
    end

    assign sts.div_done   = (bit_cnt_reg == BIT_W'(VALUE_BITS - 1));
    assign sts.quot_zero  = (quot_reg == '0);
    assign sts.stack_full = (n_reg == CNT_W'(DIGIT_LIMIT - 1));
    assign sts.one_left   = (n_reg == CNT_W'(1));

    assign top_digit = stack_reg[0];

    always_comb
    begin
        if (top_digit < DEC_BASE)
            result.character = CHAR_ZERO + {4'b0, top_digit};
        else
            result.character = CHAR_A + {4'b0, top_digit - DEC_BASE};
        result.last = sts.one_left;
    end

endmodule

`default_nettype wire

// File: sv/itra_ctrl.sv
// controller: sequences division, digit push and character emission
`timescale 1ns / 1ps
`default_nettype none

module itra_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire itra_pkg::dp_sts_t sts,
    output itra_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   strobe
);
    import itra_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PUSH = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_done)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (sts.quot_zero || sts.stack_full)
                    state_next = ST_EMIT;
                else
                    state_next = ST_DIV;
            end
            ST_EMIT:
            begin
                cmd.pop = 1'b1;
                if (sts.one_left)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = (state_reg == ST_EMIT);

endmodule

`default_nettype wire

// File: sv/itra_check.sv
// port-level checker for the radix ascii converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module itra_check (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              strobe,
    input wire itra_pkg::result_t result
);
    import itra_pkg::*;

    // a result beat only while busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result beat while idle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> (!strobe && !busy))
        else $error("activity after last character");

    a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(strobe && result.last))
        else $error("busy dropped without a last character");

    a_char_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((result.character >= CHAR_ZERO && result.character <= 8'h39) ||
                    (result.character >= CHAR_A && result.character <= 8'h66)))
        else $error("character is not a digit");

endmodule

bind integer_to_radix_ascii_top itra_check u_check (.*);

`default_nettype wire
